### design/mexp_pkg.sv
package mexp_pkg;

    localparam int DATA_BITS            = 32;
    localparam int OPERAND_BITS_DEFAULT = 32;

    localparam logic [DATA_BITS-1:0] MODULUS_RESET = DATA_BITS'(1);

endpackage

### design/mexp_if.sv
interface mexp_cfg_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

interface mexp_in_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] base_value;
    logic [DATA_BITS-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

### design/mexp_modmul.sv
module mexp_modmul #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [OPERAND_BITS-1:0] mult_x,
    input  logic [OPERAND_BITS-1:0] mult_y,
    input  logic [OPERAND_BITS:0]   modulus,
    output logic                    done,
    output logic [OPERAND_BITS-1:0] product
);
    import mexp_pkg::*;

    localparam int CNT_BITS = $clog2(OPERAND_BITS);

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_DOUBLE,
        MM_ADD
    } mm_state_t;

    mm_state_t               state_reg;
    logic [CNT_BITS-1:0]     count_reg;
    logic                    done_reg;
    logic [OPERAND_BITS-1:0] acc_reg;
    logic [OPERAND_BITS-1:0] x_reg;
    logic [OPERAND_BITS-1:0] y_reg;

    logic [OPERAND_BITS-1:0] addend;
    logic [OPERAND_BITS:0]   sum;
    logic [OPERAND_BITS:0]   diff;
    logic [OPERAND_BITS-1:0] reduced;

    // shared modular adder: one double or one add per cycle
    always_comb
    begin
        addend  = (state_reg == MM_DOUBLE) ? acc_reg : x_reg;
        sum     = {1'b0, acc_reg} + {1'b0, addend};
        diff    = sum - modulus;
        reduced = (sum >= modulus) ? diff[OPERAND_BITS-1:0] : sum[OPERAND_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MM_IDLE:
                begin
                    if (start)
                    begin
                        acc_reg   <= '0;
                        x_reg     <= mult_x;
                        y_reg     <= mult_y;
                        count_reg <= CNT_BITS'(OPERAND_BITS - 1);
                        state_reg <= MM_DOUBLE;
                    end
                end
                MM_DOUBLE:
                begin
                    acc_reg <= reduced;
                    if (y_reg[OPERAND_BITS-1])
                    begin
                        state_reg <= MM_ADD;
                    end
                    else if (count_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= MM_IDLE;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        y_reg     <= y_reg << 1;
                    end
                end
                MM_ADD:
                begin
                    acc_reg <= reduced;
                    if (count_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= MM_IDLE;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        y_reg     <= y_reg << 1;
                        state_reg <= MM_DOUBLE;
                    end
                end
                default:
                begin
                    state_reg <= MM_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### design/modular_exponentiation.sv
// modular exponentiation, right-to-left square and multiply
// cfg: write the modulus (reset value 1); only while no operation is in flight
// operand: base_value and exponent, one transfer starts one operation
// result: power_result, one transfer per operation
// a zero exponent gives 1; a modulus of zero wraps at OPERAND_BITS bits
// every modular multiply runs on one shift-and-add unit with a shared
// modular adder, one double or one add per cycle; a multiply does one double
// per multiplier bit and one add per set multiplier bit
// an operation with a nonzero exponent is one reduction of the base, one
// square per exponent bit below the top set bit, and one multiply per set exponent bit
// operand.ready is high only while the sequencer is idle
// the result register holds a finished value while the receiver stalls;
// the next operand may be taken meanwhile, and a later result waits for it
// reset clears the sequencer, drops result.valid and sets the modulus to 1
module modular_exponentiation #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
    input logic  clk,
    input logic  rst_n,
    mexp_cfg_if.sink   cfg,
    mexp_in_if.sink    operand,
    mexp_out_if.source result
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MULT,
        ST_SQUARE,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [DATA_BITS-1:0]    modulus_reg;
    logic [OPERAND_BITS-1:0] base_reg;
    logic [OPERAND_BITS-1:0] exp_reg;
    logic [OPERAND_BITS-1:0] acc_reg;
    logic                    mm_start_reg;
    logic [OPERAND_BITS-1:0] mm_x_reg;
    logic [OPERAND_BITS-1:0] mm_y_reg;
    logic                    out_valid_reg;
    logic [DATA_BITS-1:0]    out_reg;

    logic [OPERAND_BITS-1:0] mod_op;
    logic [OPERAND_BITS:0]   mod_ext;
    logic [OPERAND_BITS-1:0] in_base;
    logic [OPERAND_BITS-1:0] in_exp;
    logic [OPERAND_BITS-1:0] exp_next;
    logic                    mm_done;
    logic [OPERAND_BITS-1:0] mm_product;

    assign mod_op   = OPERAND_BITS'(modulus_reg);
    assign mod_ext  = {(mod_op == '0), mod_op};
    assign in_base  = OPERAND_BITS'(operand.base_value);
    assign in_exp   = OPERAND_BITS'(operand.exponent);
    assign exp_next = exp_reg >> 1;

    assign cfg.ready           = 1'b1;
    assign operand.ready       = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.power_result = out_reg;

    mexp_modmul #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start_reg),
        .mult_x  (mm_x_reg),
        .mult_y  (mm_y_reg),
        .modulus (mod_ext),
        .done    (mm_done),
        .product (mm_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= MODULUS_RESET;
            mm_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mm_start_reg <= 1'b0;

            if (cfg.valid)
            begin
                modulus_reg <= cfg.modulus;
            end

            if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (operand.valid)
                    begin
                        exp_reg <= in_exp;
                        acc_reg <= OPERAND_BITS'(1);
                        if (in_exp == '0)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            // base mod m as 1 * base mod m
                            mm_x_reg     <= OPERAND_BITS'(1);
                            mm_y_reg     <= in_base;
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE, ST_SQUARE:
                begin
                    if (mm_done)
                    begin
                        base_reg     <= mm_product;
                        mm_start_reg <= 1'b1;
                        if (exp_reg[0])
                        begin
                            mm_x_reg  <= acc_reg;
                            mm_y_reg  <= mm_product;
                            state_reg <= ST_MULT;
                        end
                        else
                        begin
                            exp_reg   <= exp_next;
                            mm_x_reg  <= mm_product;
                            mm_y_reg  <= mm_product;
                            state_reg <= ST_SQUARE;
                        end
                    end
                end
                ST_MULT:
                begin
                    if (mm_done)
                    begin
                        acc_reg <= mm_product;
                        exp_reg <= exp_next;
                        if (exp_next == '0)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            mm_x_reg     <= base_reg;
                            mm_y_reg     <= base_reg;
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_SQUARE;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_reg       <= DATA_BITS'(acc_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### dv/mexp_result_checker.sv
`timescale 1ns / 100ps

module mexp_result_checker
    import mexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mexp_cfg_if        cfg,
    mexp_in_if         operand,
    mexp_out_if        result,
    output int         mismatches,
    output int         outstanding
);

    logic [DATA_BITS-1:0] modulus_now;
    logic [DATA_BITS-1:0] expected_power;
    logic [DATA_BITS-1:0] pending_powers[$];

    // right-to-left square and multiply, a zero modulus wraps at the data width
    function automatic logic [DATA_BITS-1:0] power_mod(
        input logic [DATA_BITS-1:0] b,
        input logic [DATA_BITS-1:0] e,
        input logic [DATA_BITS-1:0] m
    );
        logic [2*DATA_BITS-1:0] base_r;
        logic [2*DATA_BITS-1:0] acc;
        logic [2*DATA_BITS-1:0] prod;
        base_r = (m != '0) ? b % m : b;
        acc    = 1;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            if (e[i])
            begin
                prod = acc * base_r;
                acc  = (m != '0) ? prod % m : prod[DATA_BITS-1:0];
            end
            prod   = base_r * base_r;
            base_r = (m != '0) ? prod % m : prod[DATA_BITS-1:0];
        end
        return acc[DATA_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_now = MODULUS_RESET;
            pending_powers.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                modulus_now = cfg.modulus;
            if (operand.valid && operand.ready)
                pending_powers.push_back(power_mod(operand.base_value, operand.exponent,
                                                   modulus_now));
            if (result.valid && result.ready)
            begin
                if (pending_powers.size() == 0)
                begin
                    $error("power_result transfer with nothing pending: actual %h",
                           result.power_result);
                    mismatches++;
                end
                else
                begin
                    expected_power = pending_powers.pop_front();
                    if (result.power_result !== expected_power)
                    begin
                        $error("power_result mismatch: expected %h, actual %h",
                               expected_power, result.power_result);
                        mismatches++;
                    end
                end
            end
            outstanding = pending_powers.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mexp_pkg::*;

    localparam int GAP_MAX         = 11;
    localparam int QUIET_LIMIT     = 20000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 17;

    logic clk;
    logic rst_n;
    bit   steady;
    int   mismatches;
    int   outstanding;
    int   sent        = 0;
    int   settings    = 0;
    int   quiet_cycles = 0;

    mexp_cfg_if cfg_bus ();
    mexp_in_if  operand_bus ();
    mexp_out_if result_bus ();

    modular_exponentiation u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .operand (operand_bus),
        .result  (result_bus)
    );

    mexp_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_bus),
        .operand     (operand_bus),
        .result      (result_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_operand(input logic [DATA_BITS-1:0] b, input logic [DATA_BITS-1:0] e);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            operand_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_bus.valid      <= 1'b1;
        operand_bus.base_value <= b;
        operand_bus.exponent   <= e;
        do @(posedge clk); while (!operand_bus.ready);
        sent++;
    endtask

    // hold the sender until every pending result has been transferred
    task automatic drain();
        operand_bus.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_modulus(input logic [DATA_BITS-1:0] m);
        drain();
        cfg_bus.valid   <= 1'b1;
        cfg_bus.modulus <= m;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [DATA_BITS-1:0] pick_modulus();
        case ($urandom_range(0, 4))
            0:       return DATA_BITS'($urandom_range(1, 16));
            1:       return DATA_BITS'($urandom_range(17, 65535));
            2:       return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_BITS-1:0] pick_base(input logic [DATA_BITS-1:0] m);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return m - 1'b1;
            3:       return m;
            4:       return m + 1'b1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_BITS-1:0] pick_exponent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DATA_BITS'(1);
            2:       return '1;
            3, 4:    return $urandom >> $urandom_range(8, 31);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int stall;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (!result_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        if ((cfg_bus.valid && cfg_bus.ready) || (operand_bus.valid && operand_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [DATA_BITS-1:0] m;
        steady                 = 1'b0;
        rst_n                  <= 1'b0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.modulus        <= '0;
        operand_bus.valid      <= 1'b0;
        operand_bus.base_value <= '0;
        operand_bus.exponent   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // modulus of one after reset: zero exponent still gives one
        send_operand(32'd5, 32'd0);
        send_operand(32'd7, 32'd3);
        send_operand(32'd0, 32'd0);

        write_modulus('1);
        send_operand('1, '1);
        send_operand('1, 32'd1);
        send_operand('0, '1);
        send_operand(32'd1, '1);
        send_operand('0, '0);
        send_operand('1, '0);

        // zero modulus wraps at the operand width
        write_modulus('0);
        send_operand(32'd3, '1);
        send_operand('1, 32'd2);
        send_operand(32'h0001_0001, 32'h0001_0001);
        send_operand(32'd2, 32'd31);
        send_operand(32'd2, 32'd32);

        write_modulus(32'd65521);
        send_operand(32'd65520, 32'd65520);
        send_operand(32'd65521, 32'd5);
        send_operand(32'd65522, 32'd3);
        send_operand(32'd123456789, 32'd65520);

        write_modulus(32'h8000_0000);
        send_operand(32'd3, '1);
        send_operand(32'h8000_0000, 32'd1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            steady = (ph % 3 == 2);
            m = pick_modulus();
            write_modulus(m);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_operand(pick_base(m), pick_exponent());
        end

        steady = 1'b0;
        drain();
        repeat (50) @(posedge clk);
        $display("%0d operand transfers checked over %0d modulus writes", sent, settings);
        $display("moduli covered: one, zero, all ones, top bit only, prime, random");
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
design/mexp_pkg.sv
design/mexp_if.sv
design/mexp_modmul.sv
design/modular_exponentiation.sv
dv/mexp_result_checker.sv
dv/tb_top.sv
